// File: src/idt_pkg.sv
// Shared constants, types and codes of the idempotency table.
`timescale 1ns / 1ps
package idt_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int KEY_W   = 64;
  localparam int DIG_W   = 64;
  localparam int ST_W    = 4;
  localparam int STAMP_W = 63;
  localparam int RC_W    = 2;

  localparam int IN_DATA_W  = 200;
  localparam int OUT_DATA_W = 8;

  localparam logic [STAMP_W-1:0] STAMP_START = {STAMP_W{1'b1}};

  localparam logic OP_LOOKUP   = 1'b0;
  localparam logic OP_REMEMBER = 1'b1;

  localparam logic [RC_W-1:0] RC_OK        = 2'd0;
  localparam logic [RC_W-1:0] RC_NOT_FOUND = 2'd1;
  localparam logic [RC_W-1:0] RC_CONFLICT  = 2'd2;

  // Search token that walks down the row of cells, one cell per cycle.
  typedef struct packed {
    logic               valid;
    logic               found;
    logic [IDX_W-1:0]   hit_idx;
    logic               dig_eq;
    logic [ST_W-1:0]    status;
    logic               empty_found;
    logic [IDX_W-1:0]   empty_idx;
    logic [STAMP_W-1:0] oldest_stamp;
    logic [IDX_W-1:0]   oldest_idx;
  } probe_t;

  // Write command broadcast to all cells at the end of a scan.
  typedef struct packed {
    logic               full;
    logic               upd;
    logic [IDX_W-1:0]   idx;
    logic [KEY_W-1:0]   key;
    logic [DIG_W-1:0]   digest;
    logic [ST_W-1:0]    status;
    logic [STAMP_W-1:0] stamp;
  } wr_t;

endpackage

// File: src/idt_cell.sv
// One table entry with its slice of the key search and the replacement search.
`timescale 1ns / 1ps
module idt_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [idt_pkg::IDX_W-1:0]   cell_idx,
  input  logic [idt_pkg::KEY_W-1:0]   q_key,
  input  logic [idt_pkg::DIG_W-1:0]   q_digest,
  input  idt_pkg::probe_t             probe_in,
  input  idt_pkg::wr_t                wr,
  output idt_pkg::probe_t             probe_out
);

  logic                         valid_r;
  logic [idt_pkg::KEY_W-1:0]    key_r;
  logic [idt_pkg::DIG_W-1:0]    digest_r;
  logic [idt_pkg::ST_W-1:0]     status_r;
  logic [idt_pkg::STAMP_W-1:0]  stamp_r;
  idt_pkg::probe_t              probe_r;
  idt_pkg::probe_t              probe_nxt;
  logic                         wr_hit;

  assign wr_hit = (wr.idx == cell_idx);

  always_comb begin
    probe_nxt = probe_in;
    if (!probe_in.found && valid_r && (key_r == q_key)) begin
      probe_nxt.found   = 1'b1;
      probe_nxt.hit_idx = cell_idx;
      probe_nxt.dig_eq  = (digest_r == q_digest);
      probe_nxt.status  = status_r;
    end
    if (!valid_r && !probe_in.empty_found) begin
      probe_nxt.empty_found = 1'b1;
      probe_nxt.empty_idx   = cell_idx;
    end
    // Strictly older only, so the first of equal stamps is kept.
    if (valid_r && (stamp_r < probe_in.oldest_stamp)) begin
      probe_nxt.oldest_stamp = stamp_r;
      probe_nxt.oldest_idx   = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      if (wr.full && wr_hit) begin
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r.valid <= 1'b0;
    end else begin
      probe_r.valid <= probe_in.valid;
    end
    probe_r.found        <= probe_nxt.found;
    probe_r.hit_idx      <= probe_nxt.hit_idx;
    probe_r.dig_eq       <= probe_nxt.dig_eq;
    probe_r.status       <= probe_nxt.status;
    probe_r.empty_found  <= probe_nxt.empty_found;
    probe_r.empty_idx    <= probe_nxt.empty_idx;
    probe_r.oldest_stamp <= probe_nxt.oldest_stamp;
    probe_r.oldest_idx   <= probe_nxt.oldest_idx;
    if (wr_hit && wr.full) begin
      key_r    <= wr.key;
      digest_r <= wr.digest;
    end
    if (wr_hit && (wr.full || wr.upd)) begin
      status_r <= wr.status;
      stamp_r  <= wr.stamp;
    end
  end

  assign probe_out = probe_r;

endmodule

// File: src/idempotency_table_top.sv
// Top level of the idempotency table: stream ports, sequencer and the row of entry cells.
`timescale 1ns / 1ps
// A fully associative command deduplication table of idt_pkg::TABLE_ENTRIES
// entries, each entry living in its own cell of a row. One transaction is
// handled at a time: after a command is accepted, a search token walks down
// the row one cell per clock, collecting the first valid entry whose key
// matches, the first empty entry and the strictly oldest stamp. When the
// token leaves the last cell, a remember writes the chosen cell (a key hit
// updates status and stamp only; otherwise the first empty entry, else the
// oldest entry, is filled) and the result is registered.
// After acceptance the token passes every cell of the row; as it leaves,
// the write and the result register follow, and the hold state then moves
// the result into the output register once that is free and reopens the
// input. The output register lets the next command be accepted while a
// result still waits. Every entry is empty after reset, and no clearing pass is needed.
module idempotency_table_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [63:0] command_key, [127:64] payload_digest, [131:128] action_state,
  // [194:132] time_now, [199:195] zero
  input  logic [idt_pkg::IN_DATA_W-1:0]   in_tdata,
  // [0] operation
  input  logic [0:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [1:0] result_code, [5:2] stored_state, [7:6] zero
  output logic [idt_pkg::OUT_DATA_W-1:0]  out_tdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0]                      state_r;
  logic [1:0]                      state_nxt;
  logic                            start_r;
  logic                            q_op_r;
  logic [idt_pkg::KEY_W-1:0]       q_key_r;
  logic [idt_pkg::DIG_W-1:0]       q_digest_r;
  logic [idt_pkg::ST_W-1:0]        q_status_r;
  logic [idt_pkg::STAMP_W-1:0]     q_stamp_r;
  logic [idt_pkg::RC_W-1:0]        res_code_r;
  logic [idt_pkg::ST_W-1:0]        res_state_r;
  logic                            out_valid_r;
  logic [idt_pkg::RC_W-1:0]        out_code_r;
  logic [idt_pkg::ST_W-1:0]        out_state_r;

  logic                            in_fire;
  logic                            scan_end;
  logic                            out_load;
  idt_pkg::probe_t                 head;
  idt_pkg::probe_t                 tail;
  idt_pkg::wr_t                    wr;
  idt_pkg::probe_t                 chain [idt_pkg::TABLE_ENTRIES];

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign tail      = chain[idt_pkg::TABLE_ENTRIES-1];
  assign scan_end  = (state_r == S_SCAN) && tail.valid;
  assign out_load  = (state_r == S_HOLD) && (!out_valid_r || out_tready);

  // Fresh token entering the first cell.
  always_comb begin
    head              = '0;
    head.valid        = start_r;
    head.oldest_stamp = idt_pkg::STAMP_START;
  end

  // Write issued in the cycle the token leaves the row.
  always_comb begin
    wr        = '0;
    wr.key    = q_key_r;
    wr.digest = q_digest_r;
    wr.status = q_status_r;
    wr.stamp  = q_stamp_r;
    if (scan_end && (q_op_r == idt_pkg::OP_REMEMBER)) begin
      wr.upd  = tail.found;
      wr.full = !tail.found;
    end
    if (tail.found) begin
      wr.idx = tail.hit_idx;
    end else if (tail.empty_found) begin
      wr.idx = tail.empty_idx;
    end else begin
      wr.idx = tail.oldest_idx;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < idt_pkg::TABLE_ENTRIES; gi++) begin : g_cell
      idt_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .cell_idx  (idt_pkg::IDX_W'(gi)),
        .q_key     (q_key_r),
        .q_digest  (q_digest_r),
        .probe_in  ((gi == 0) ? head : chain[(gi == 0) ? 0 : gi-1]),
        .wr        (wr),
        .probe_out (chain[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= in_fire;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      q_op_r     <= in_tuser[0];
      q_key_r    <= in_tdata[63:0];
      q_digest_r <= in_tdata[127:64];
      q_status_r <= in_tdata[131:128];
      q_stamp_r  <= in_tdata[194:132];
    end
    if (scan_end) begin
      res_state_r <= '0;
      if (q_op_r == idt_pkg::OP_REMEMBER) begin
        res_code_r <= idt_pkg::RC_OK;
      end else if (!tail.found) begin
        res_code_r <= idt_pkg::RC_NOT_FOUND;
      end else if (!tail.dig_eq) begin
        res_code_r <= idt_pkg::RC_CONFLICT;
      end else begin
        res_code_r  <= idt_pkg::RC_OK;
        res_state_r <= tail.status;
      end
    end
    if (out_load) begin
      out_code_r  <= res_code_r;
      out_state_r <= res_state_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_state_r, out_code_r};

endmodule

// File: src/idt_checker.sv
// Port-level checks of the idempotency table and their binding to the top level.
`timescale 1ns / 1ps
module idt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [idt_pkg::IN_DATA_W-1:0]   in_tdata,
  input logic [0:0]                      in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [idt_pkg::OUT_DATA_W-1:0]  out_tdata
);

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Only the three defined result codes appear.
  a_code_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] == idt_pkg::RC_OK) ||
                   (out_tdata[1:0] == idt_pkg::RC_NOT_FOUND) ||
                   (out_tdata[1:0] == idt_pkg::RC_CONFLICT))
    else $error("illegal result code");

  // A status is reported only with an ok result.
  a_state_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] != idt_pkg::RC_OK) |-> out_tdata[5:2] == '0)
    else $error("status reported on a failed lookup");

  // One command at a time: the table is busy right after an acceptance.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second command accepted during a scan");

endmodule

bind idempotency_table_top idt_checker u_idt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: dv/idempotency_table_top_test.sv
// Self-checking testbench of the idempotency table: directed table, random commands, scoreboard.
`timescale 1ns / 1ps
module idempotency_table_top_test;

  // Bound on the whole run, in clock cycles. The slowest correct run is about
  // 780 commands, each with the scan in the block, idle gaps at the sender
  // and receiver stalls, which stays well under this bound.
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_ITEMS = 750;
  localparam int KEY_POOL = 24;
  localparam logic [idt_pkg::STAMP_W-1:0] STAMP_MAX = '1;
  localparam logic [idt_pkg::KEY_W-1:0] KEY_MAX = '1;
  localparam logic [idt_pkg::DIG_W-1:0] DIG_MAX = '1;

  // One command as it travels on the input stream.
  typedef struct {
    logic                        op;
    logic [idt_pkg::KEY_W-1:0]   key;
    logic [idt_pkg::DIG_W-1:0]   digest;
    logic [idt_pkg::ST_W-1:0]    status;
    logic [idt_pkg::STAMP_W-1:0] now;
  } command_t;

  // One answer as it comes back on the output stream.
  typedef struct {
    logic [idt_pkg::RC_W-1:0] code;
    logic [idt_pkg::ST_W-1:0] status;
  } answer_t;

  // A row of the directed table. When fixed is set the answer is typed in
  // below; otherwise it comes from the table model.
  typedef struct {
    command_t cmd;
    logic     fixed;
    answer_t  ans;
  } directed_row_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [idt_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic [0:0]                     in_tuser = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [idt_pkg::OUT_DATA_W-1:0] out_tdata;

  // Shadow copy of the table contents, kept in step with every accepted command.
  logic                        shadow_valid [idt_pkg::TABLE_ENTRIES];
  logic [idt_pkg::KEY_W-1:0]   shadow_key   [idt_pkg::TABLE_ENTRIES];
  logic [idt_pkg::DIG_W-1:0]   shadow_digest[idt_pkg::TABLE_ENTRIES];
  logic [idt_pkg::ST_W-1:0]    shadow_status[idt_pkg::TABLE_ENTRIES];
  logic [idt_pkg::STAMP_W-1:0] shadow_stamp [idt_pkg::TABLE_ENTRIES];

  answer_t       pending_answers[$];
  directed_row_t directed_rows[$];
  int            mismatches = 0;
  int            cycle_count = 0;
  // While set, neither side idles, so the block runs back to back.
  logic          no_idle = 1'b0;

  idempotency_table_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Computes the answer to one command and applies its effect on the shadow
  // table: a lookup scans for the first valid matching key, a remember
  // either refreshes status and stamp of a hit or fills a chosen entry.
  function automatic answer_t table_answer(command_t c);
    answer_t                     a;
    int                          hit;
    int                          slot;
    logic [idt_pkg::STAMP_W-1:0] oldest;
    a.code = idt_pkg::RC_OK;
    a.status = '0;
    hit = -1;
    for (int i = 0; i < idt_pkg::TABLE_ENTRIES; i++) begin
      if (hit < 0 && shadow_valid[i] && shadow_key[i] == c.key) begin
        hit = i;
      end
    end
    if (c.op == idt_pkg::OP_LOOKUP) begin
      if (hit < 0) begin
        a.code = idt_pkg::RC_NOT_FOUND;
      end else if (shadow_digest[hit] != c.digest) begin
        a.code = idt_pkg::RC_CONFLICT;
      end else begin
        a.status = shadow_status[hit];
      end
    end else if (hit >= 0) begin
      // The stored digest stays as it was on a refresh.
      shadow_status[hit] = c.status;
      shadow_stamp[hit] = c.now;
    end else begin
      // First empty entry wins; else the strictly oldest stamp, first on
      // ties. With every stamp at its maximum nothing is older than the
      // starting value and entry 0 is taken.
      slot = -1;
      for (int i = 0; i < idt_pkg::TABLE_ENTRIES; i++) begin
        if (slot < 0 && !shadow_valid[i]) begin
          slot = i;
        end
      end
      if (slot < 0) begin
        slot = 0;
        oldest = idt_pkg::STAMP_START;
        for (int i = 0; i < idt_pkg::TABLE_ENTRIES; i++) begin
          if (shadow_stamp[i] < oldest) begin
            oldest = shadow_stamp[i];
            slot = i;
          end
        end
      end
      shadow_valid[slot] = 1'b1;
      shadow_key[slot] = c.key;
      shadow_digest[slot] = c.digest;
      shadow_status[slot] = c.status;
      shadow_stamp[slot] = c.now;
    end
    return a;
  endfunction

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) begin
      return 0;
    end else if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else begin
      return $urandom_range(10, 40);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch in %s at cycle %0d: got %0h, expected %0h",
             what, cycle_count, got, want);
    mismatches++;
  endtask

  function automatic void add_row(logic op, logic [idt_pkg::KEY_W-1:0] key,
                                  logic [idt_pkg::DIG_W-1:0] digest,
                                  logic [idt_pkg::ST_W-1:0] status,
                                  logic [idt_pkg::STAMP_W-1:0] now,
                                  logic fixed, logic [idt_pkg::RC_W-1:0] code,
                                  logic [idt_pkg::ST_W-1:0] ans_status);
    directed_row_t row;
    row.cmd.op = op;
    row.cmd.key = key;
    row.cmd.digest = digest;
    row.cmd.status = status;
    row.cmd.now = now;
    row.fixed = fixed;
    row.ans.code = code;
    row.ans.status = ans_status;
    directed_rows.push_back(row);
  endfunction

  // Presents one command and holds it until it is accepted. The
  // expected answer is queued at the accepting edge. tvalid is left high so
  // that a following command can go out without a gap.
  task automatic send_command(input command_t c, input logic fixed, input answer_t typed);
    answer_t predicted;
    in_tvalid <= 1'b1;
    in_tuser <= c.op;
    in_tdata <= {5'b0, c.now, c.status, c.digest, c.key};
    do @(posedge clk); while (!in_tready);
    predicted = table_answer(c);
    pending_answers.push_back(fixed ? typed : predicted);
  endtask

  task automatic pause_sender(input int n);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Global cycle bound: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("idempotency_table_top verification failed");
      $finish;
    end
  end

  // Receiver: alternating runs of ready and stall.
  initial begin : drive_ready
    int run;
    int stall;
    @(posedge clk);
    forever begin
      run = $urandom_range(1, 12);
      stall = idle_cycles();
      if (stall > 40) begin
        stall = 60;
      end
      out_tready <= 1'b1;
      repeat (run) @(posedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Scoreboard: each output transaction is matched against the oldest
  // pending answer, field by field, including the zero padding.
  always @(posedge clk) begin : check_answers
    answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected transaction", out_tdata, 8'h00);
      end else begin
        want = pending_answers.pop_front();
        if (out_tdata[1:0] !== want.code) begin
          report_mismatch("result_code", {6'b0, out_tdata[1:0]}, {6'b0, want.code});
        end
        if (out_tdata[5:2] !== want.status) begin
          report_mismatch("stored_state", {4'b0, out_tdata[5:2]}, {4'b0, want.status});
        end
        if (out_tdata[7:6] !== 2'b00) begin
          report_mismatch("padding", {6'b0, out_tdata[7:6]}, 8'h00);
        end
      end
    end
  end

  initial begin : stimulus
    logic [idt_pkg::KEY_W-1:0]   pool_key[KEY_POOL];
    logic [idt_pkg::DIG_W-1:0]   pool_digest[KEY_POOL];
    logic [idt_pkg::STAMP_W-1:0] wall_clock;
    command_t                    c;
    answer_t                     none;
    int                          p;
    int                          r;

    for (int i = 0; i < idt_pkg::TABLE_ENTRIES; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_key[i] = '0;
      shadow_digest[i] = '0;
      shadow_status[i] = '0;
      shadow_stamp[i] = '0;
    end
    none.code = idt_pkg::RC_OK;
    none.status = '0;

    // Directed table. An empty table misses on any key, zero included.
    add_row(idt_pkg::OP_LOOKUP, '0, '0, '0, '0, 1'b1, idt_pkg::RC_NOT_FOUND, '0);
    add_row(idt_pkg::OP_LOOKUP, KEY_MAX, DIG_MAX, 4'hF, STAMP_MAX, 1'b1,
            idt_pkg::RC_NOT_FOUND, '0);
    // Key zero is an ordinary key; remember always answers ok with status 0.
    add_row(idt_pkg::OP_REMEMBER, '0, '0, '0, '0, 1'b1, idt_pkg::RC_OK, '0);
    add_row(idt_pkg::OP_LOOKUP, '0, '0, 4'hF, STAMP_MAX, 1'b0, idt_pkg::RC_OK, '0);
    add_row(idt_pkg::OP_LOOKUP, '0, DIG_MAX, '0, '0, 1'b1, idt_pkg::RC_CONFLICT, '0);
    add_row(idt_pkg::OP_REMEMBER, KEY_MAX, DIG_MAX, 4'hF, STAMP_MAX, 1'b1,
            idt_pkg::RC_OK, '0);
    // Refresh of an existing key with another digest: the old digest stays.
    add_row(idt_pkg::OP_REMEMBER, KEY_MAX, '0, 4'h5, 63'd1, 1'b1, idt_pkg::RC_OK, '0);
    add_row(idt_pkg::OP_LOOKUP, KEY_MAX, DIG_MAX, '0, '0, 1'b0, idt_pkg::RC_OK, '0);
    add_row(idt_pkg::OP_LOOKUP, KEY_MAX, '0, '0, '0, 1'b0, idt_pkg::RC_OK, '0);
    // Bring every stamp to the maximum and fill the table.
    add_row(idt_pkg::OP_REMEMBER, '0, '0, 4'hA, STAMP_MAX, 1'b1, idt_pkg::RC_OK, '0);
    add_row(idt_pkg::OP_REMEMBER, KEY_MAX, DIG_MAX, 4'hF, STAMP_MAX, 1'b1,
            idt_pkg::RC_OK, '0);
    for (int i = 1; i <= idt_pkg::TABLE_ENTRIES - 2; i++) begin
      add_row(idt_pkg::OP_REMEMBER, {$urandom, $urandom}, {$urandom, $urandom},
              i[idt_pkg::ST_W-1:0], STAMP_MAX, 1'b1, idt_pkg::RC_OK, '0);
    end
    // Nothing is strictly older than the maximum, so entry 0 (key zero) goes.
    add_row(idt_pkg::OP_REMEMBER, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
            4'h3, '0, 1'b1, idt_pkg::RC_OK, '0);
    add_row(idt_pkg::OP_LOOKUP, '0, '0, '0, '0, 1'b0, idt_pkg::RC_OK, '0);
    add_row(idt_pkg::OP_LOOKUP, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
            '0, '0, 1'b0, idt_pkg::RC_OK, '0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_command(directed_rows[i].cmd, directed_rows[i].fixed, directed_rows[i].ans);
      pause_sender(idle_cycles());
    end

    // Random part: mostly keys from a pool a bit larger than the table, so
    // that hits, refreshes and oldest-entry evictions all happen, with stray
    // keys and digests as noise. Stamps mix a rising clock, ties, random
    // values and the maximum.
    for (int k = 0; k < KEY_POOL; k++) begin
      pool_key[k] = {$urandom, $urandom};
      pool_digest[k] = {$urandom, $urandom};
    end
    wall_clock = {23'h0, 8'($urandom_range(0, 255)), 32'h0};
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle <= ((n % 250) < 40);
      if (n == RANDOM_ITEMS / 2) begin
        // Let the block drain completely before going on.
        in_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
      end
      c.op = 1'($urandom_range(0, 1));
      c.status = idt_pkg::ST_W'($urandom_range(0, 15));
      p = $urandom_range(0, KEY_POOL - 1);
      if ($urandom_range(0, 99) < 82) begin
        c.key = pool_key[p];
        c.digest = ($urandom_range(0, 99) < 75) ? pool_digest[p] : {$urandom, $urandom};
      end else begin
        c.key = {$urandom, $urandom};
        c.digest = {$urandom, $urandom};
      end
      r = $urandom_range(0, 99);
      if (r < 45) begin
        wall_clock = wall_clock + idt_pkg::STAMP_W'($urandom_range(1, 1000));
        c.now = wall_clock;
      end else if (r < 60) begin
        c.now = wall_clock;
      end else if (r < 75) begin
        c.now = idt_pkg::STAMP_W'($urandom_range(0, 3));
      end else if (r < 92) begin
        c.now = idt_pkg::STAMP_W'({$urandom, $urandom});
      end else begin
        c.now = STAMP_MAX;
      end
      send_command(c, 1'b0, none);
      pause_sender(idle_cycles());
    end
    in_tvalid <= 1'b0;

    // Drain, then allow a full command latency for any stray transaction.
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (idt_pkg::TABLE_ENTRIES + 24) @(posedge clk);
    if (mismatches == 0) begin
      $display("idempotency_table_top verification clean");
    end else begin
      $display("idempotency_table_top verification failed");
    end
    $finish;
  end

endmodule
